// ===== rtl/simt_register_file_with_clone_macros.svh =====
// Assertion macros used by the checker of the register file.
`ifndef SIMT_REGISTER_FILE_WITH_CLONE_MACROS_SVH
`define SIMT_REGISTER_FILE_WITH_CLONE_MACROS_SVH

// Check that post holds in the same cycle as pre.
`define SRFC_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("srfc check failed");

// Check that post holds in the cycle after pre.
`define SRFC_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("srfc check failed");

`endif

// ===== rtl/srfc_pkg.sv =====
`timescale 1ns / 1ps
package srfc_pkg;

   // Store geometry
   localparam int WARPS       = 8;
   localparam int LANES       = 4;
   localparam int REGS        = 8;
   localparam int DATA_WIDTH  = 32;

   // Item layout
   localparam int FIELD_LANES = 4;
   localparam int OPS         = 3;
   localparam int OP_W        = 32;
   localparam int FIELD_IDX_W = 3;
   localparam int MASK_W      = 4;
   localparam int CLONE_W     = 4;
   localparam int MODE_W      = 2;

   localparam int OFS_WARP    = 0;
   localparam int OFS_SRC     = OFS_WARP + FIELD_IDX_W;
   localparam int OFS_DST     = OFS_SRC + OPS * FIELD_IDX_W;
   localparam int OFS_MASK    = OFS_DST + FIELD_IDX_W;
   localparam int OFS_VALUE   = OFS_MASK + MASK_W;
   localparam int OFS_CLONE   = OFS_VALUE + FIELD_LANES * OP_W;
   localparam int REQ_BITS    = OFS_CLONE + CLONE_W;
   localparam int REQ_W       = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W       = OPS * FIELD_LANES * OP_W;

   // Derived widths
   localparam int WARP_IDX_W  = ($clog2(WARPS) > FIELD_IDX_W) ? $clog2(WARPS) : FIELD_IDX_W;
   localparam int REG_IDX_W   = ($clog2(REGS) > FIELD_IDX_W) ? $clog2(REGS) : FIELD_IDX_W;
   localparam int LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int DEPTH       = WARPS * REGS;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int STEP_W      = $clog2(REGS + 1);

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_CLONE = 2'd2
   } srfc_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_HOLD,
      ST_CLONE
   } srfc_state_type;

   typedef struct packed {
      logic                  en;
      logic [WARP_IDX_W-1:0] warp;
      logic [REG_IDX_W-1:0]  index;
   } srfc_rd_req_type;

   typedef struct packed {
      logic                  en;
      logic [WARP_IDX_W-1:0] warp;
      logic [REG_IDX_W-1:0]  index;
      logic [DATA_WIDTH-1:0] data;
   } srfc_wr_req_type;

   // Flat entry address of one register of one warp within a lane
   function automatic logic [ADDR_W-1:0] srfc_addr(logic [WARP_IDX_W-1:0] warp,
                                                   logic [REG_IDX_W-1:0] index);
      return ADDR_W'(int'(warp) * REGS + int'(index));
   endfunction

   function automatic logic srfc_in_range(logic [WARP_IDX_W-1:0] warp,
                                          logic [REG_IDX_W-1:0] index);
      return (int'(warp) < WARPS) && (int'(index) < REGS);
   endfunction

   // Contents of an entry that was never written
   function automatic logic [DATA_WIDTH-1:0] srfc_reset_value(logic [LANE_W-1:0] lane,
                                                              logic [WARP_IDX_W-1:0] warp,
                                                              logic [REG_IDX_W-1:0] index);
      logic [DATA_WIDTH-1:0] value;
      value = '0;
      if (index == REG_IDX_W'(0)) begin
         value = DATA_WIDTH'(lane);
      end else if (index == REG_IDX_W'(1)) begin
         value = DATA_WIDTH'(warp);
      end
      return value;
   endfunction

endpackage

// ===== rtl/simt_register_file_with_clone.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Ports                        | Item
// req     | in  | req_tvalid/tready/tdata/tuser | one read, writeback or clone command
// rsp     | out | rsp_tvalid/tready/tdata       | twelve operand words of one read
//
// A writeback drives the lane writes in its accept cycle; the next item can be accepted in the following cycle.
// A read steps through ST_READ, then waits in ST_HOLD until its result can be loaded:
// each lane RAM has one read port, so the three sources are fetched one after another.
// A clone copies one register per cycle through that port, REGS (8 here) registers in all.
// Reset is synchronous; all entries read as their reset value at once, no clearing pass.
// A stalled result holds in the output register; the block keeps running until the next
// read result must be placed there.
module simt_register_file_with_clone
   import srfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // [2:0] warp, [5:3] first_source, [8:6] second_source, [11:9] third_source,
   // [14:12] dest_register, [18:15] lane_mask, [50:19] value_lane0,
   // [82:51] value_lane1, [114:83] value_lane2, [146:115] value_lane3,
   // [150:147] clone_lanes, [151] zero
   input  logic [REQ_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [MODE_W-1:0] req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // [31:0] op0_lane0 .. [127:96] op0_lane3, [159:128] op1_lane0 .. [255:224] op1_lane3,
   // [287:256] op2_lane0 .. [383:352] op2_lane3
   output logic [RSP_W-1:0] rsp_tdata
);

   srfc_state_type          state_ff, state_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [FIELD_IDX_W-1:0]  warp_ff, warp_in;
   logic [FIELD_IDX_W-1:0]  src_ff [OPS];
   logic [FIELD_IDX_W-1:0]  src_in [OPS];
   logic [LANE_W-1:0]       clone_src_ff, clone_src_in;
   logic [LANE_W-1:0]       clone_dst_ff, clone_dst_in;
   logic [OP_W-1:0]         ops_ff [OPS][FIELD_LANES];
   logic [OP_W-1:0]         ops_in [OPS][FIELD_LANES];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                    accept;
   srfc_mode_type           in_mode;
   logic [FIELD_IDX_W-1:0]  in_warp;
   logic [FIELD_IDX_W-1:0]  in_dst;
   logic [MASK_W-1:0]       in_mask;
   logic [CLONE_W-1:0]      in_clone;
   logic                    clone_ok;
   logic                    capture;
   logic                    load;
   srfc_rd_req_type         rd_req;
   srfc_wr_req_type         wr_req [FIELD_LANES];
   logic [DATA_WIDTH-1:0]   lane_rd [FIELD_LANES];
   logic [FIELD_IDX_W-1:0]  rd_src;

   // Unpack the command
   assign in_mode  = srfc_mode_type'(req_tuser);
   assign in_warp  = req_tdata[OFS_WARP +: FIELD_IDX_W];
   assign in_dst   = req_tdata[OFS_DST +: FIELD_IDX_W];
   assign in_mask  = req_tdata[OFS_MASK +: MASK_W];
   assign in_clone = req_tdata[OFS_CLONE +: CLONE_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept   = req_tvalid && req_tready;
   assign clone_ok = (int'(in_warp) < WARPS) && (int'(in_clone[1:0]) < LANES)
                     && (int'(in_clone[3:2]) < LANES) && (in_clone[1:0] != in_clone[3:2]);

   // Next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept && in_mode == MODE_READ) begin
               state_in = ST_READ;
            end else if (accept && in_mode == MODE_CLONE && clone_ok) begin
               state_in = ST_CLONE;
            end
         end
         ST_READ: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(OPS)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLONE: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(REGS)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pick the source register fetched in this read step
   always_comb begin
      case (step_ff)
         STEP_W'(0): rd_src = src_ff[0];
         STEP_W'(1): rd_src = src_ff[1];
         default:    rd_src = src_ff[2];
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      capture      = (state_ff == ST_READ) && (step_ff != '0);
      load         = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);
      rd_req.en    = 1'b0;
      rd_req.warp  = WARP_IDX_W'(warp_ff);
      rd_req.index = REG_IDX_W'(rd_src);
      if (state_ff == ST_READ && step_ff < STEP_W'(OPS)) begin
         rd_req.en = 1'b1;
      end else if (state_ff == ST_CLONE && step_ff < STEP_W'(REGS)) begin
         rd_req.en    = 1'b1;
         rd_req.index = REG_IDX_W'(step_ff);
      end
      for (int l = 0; l < FIELD_LANES; l++) begin
         wr_req[l].en    = 1'b0;
         wr_req[l].warp  = WARP_IDX_W'(in_warp);
         wr_req[l].index = REG_IDX_W'(in_dst);
         wr_req[l].data  = DATA_WIDTH'(req_tdata[OFS_VALUE + l * OP_W +: OP_W]);
         if (state_ff == ST_IDLE) begin
            wr_req[l].en = accept && (in_mode == MODE_WRITE) && in_mask[l];
         end else if (state_ff == ST_CLONE && step_ff != '0) begin
            wr_req[l].en    = (clone_dst_ff == LANE_W'(l));
            wr_req[l].warp  = WARP_IDX_W'(warp_ff);
            wr_req[l].index = REG_IDX_W'(STEP_W'(step_ff - STEP_W'(1)));
            wr_req[l].data  = lane_rd[clone_src_ff];
         end
      end
   end

   // Latch the command fields and shift captured operands in
   always_comb begin
      warp_in      = warp_ff;
      src_in       = src_ff;
      clone_src_in = clone_src_ff;
      clone_dst_in = clone_dst_ff;
      ops_in       = ops_ff;
      if (accept) begin
         warp_in      = in_warp;
         clone_src_in = LANE_W'(in_clone[1:0]);
         clone_dst_in = LANE_W'(in_clone[3:2]);
         for (int k = 0; k < OPS; k++) begin
            src_in[k] = req_tdata[OFS_SRC + k * FIELD_IDX_W +: FIELD_IDX_W];
         end
      end
      if (capture) begin
         for (int k = 0; k < OPS - 1; k++) begin
            ops_in[k] = ops_ff[k + 1];
         end
         for (int l = 0; l < FIELD_LANES; l++) begin
            ops_in[OPS-1][l] = OP_W'(lane_rd[l]);
         end
      end
   end

   // Merge the lanes into the result word and hold it until taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load) begin
         rsp_valid_in = 1'b1;
         for (int k = 0; k < OPS; k++) begin
            for (int l = 0; l < FIELD_LANES; l++) begin
               rsp_data_in[(k * FIELD_LANES + l) * OP_W +: OP_W] = ops_ff[k][l];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      warp_ff      <= warp_in;
      src_ff       <= src_in;
      clone_src_ff <= clone_src_in;
      clone_dst_ff <= clone_dst_in;
      ops_ff       <= ops_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // One storage lane per SIMT lane; absent lanes read as zero
   for (genvar g = 0; g < FIELD_LANES; g++) begin : g_lane
      if (g < LANES) begin : g_real
         srfc_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .lane_id (LANE_W'(g)),
            .rd_req  (rd_req),
            .wr_req  (wr_req[g]),
            .rd_data (lane_rd[g])
         );
      end else begin : g_absent
         assign lane_rd[g] = '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/srfc_ram.sv =====
`timescale 1ns / 1ps
module srfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word with registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/srfc_lane.sv =====
`timescale 1ns / 1ps
module srfc_lane
   import srfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [LANE_W-1:0]     lane_id,
   input  srfc_rd_req_type       rd_req,
   input  srfc_wr_req_type       wr_req,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DEPTH-1:0]      valid_ff;
   logic [DEPTH-1:0]      valid_in;
   logic                  rd_zero_ff;
   logic                  rd_valid_ff;
   logic [DATA_WIDTH-1:0] rd_dflt_ff;
   logic [DATA_WIDTH-1:0] ram_q;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  wr_ok;

   assign rd_addr = srfc_addr(rd_req.warp, rd_req.index);
   assign wr_addr = srfc_addr(wr_req.warp, wr_req.index);
   assign wr_ok   = wr_req.en && srfc_in_range(wr_req.warp, wr_req.index);

   // Mark written entries; unmarked ones read as their reset value
   always_comb begin
      valid_in = valid_ff;
      if (wr_ok) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Track how to resolve the word that the RAM returns next cycle
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_zero_ff  <= !srfc_in_range(rd_req.warp, rd_req.index);
         rd_valid_ff <= valid_ff[rd_addr];
         rd_dflt_ff  <= srfc_reset_value(lane_id, rd_req.warp, rd_req.index);
      end
   end

   srfc_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_req.data),
      .rd_en   (rd_req.en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign rd_data = rd_zero_ff  ? '0 :
                    rd_valid_ff ? ram_q : rd_dflt_ff;

endmodule

// ===== rtl/srfc_checker.sv =====
`timescale 1ns / 1ps
`include "simt_register_file_with_clone_macros.svh"
module srfc_checker
   import srfc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [MODE_W-1:0] req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_W-1:0]  rsp_tdata
);

   logic req_accept;
   logic rsp_stall;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;

   // Stalled result holds
   `SRFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // No result appears right after any accepted item
   `SRFC_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_accept, !$rose(rsp_tvalid))
   // Read occupies the lane read ports
   `SRFC_ASSERT_NEXT(a_read_busy, clock, reset, req_accept && req_tuser == MODE_READ,
                     !req_tready)
   // Writeback leaves the block ready again in the next cycle
   `SRFC_ASSERT_NEXT(a_write_quick, clock, reset, req_accept && req_tuser == MODE_WRITE,
                     req_tready)

endmodule

bind simt_register_file_with_clone srfc_checker u_srfc_checker (.*);
